// ----- hdl/cht_pkg.sv -----
// Shared types and constants of the chained hash table.
`default_nettype none

package cht_pkg;

	localparam int KEY_W = 31;
	localparam int REQ_W = 2;
	localparam int POS_W = 9;
	localparam int CFG_W = 7;
	localparam int BIT_CNT_W = $clog2(KEY_W);

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_HEAD,
		ST_POP,
		ST_INS_WR,
		ST_WALK,
		ST_UNLINK,
		ST_FREE,
		ST_DONE
	} cht_state_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             status;
	} cht_result_t;

endpackage

`default_nettype wire

// ----- hdl/cht_mod.sv -----
// Iterative remainder unit: key modulo bucket divisor, one key bit per cycle.
`default_nettype none

module cht_mod #(
	parameter int BUCKETS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cht_pkg::KEY_W-1:0]     key,
	input  wire logic [$clog2(BUCKETS+1)-1:0]  divisor,
	output logic                               done,
	output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem
);
	import cht_pkg::*;

	localparam int DW = $clog2(BUCKETS + 1);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	logic                 busy_q;
	logic                 done_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     shift_q;
	logic [DW-1:0]        div_q;
	logic [DW-1:0]        rem_q;

	logic [DW:0]   trial;
	logic [DW-1:0] rem_nxt;

	// restoring step: rem stays below divisor, so trial < 2*divisor
	always_comb begin
		trial = {rem_q, shift_q[KEY_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = DW'(trial - {1'b0, div_q});
		end else begin
			rem_nxt = trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_CNT_W'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - BIT_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= key;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[KEY_W-2:0], 1'b0};
			rem_q   <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[BW-1:0];

endmodule

`default_nettype wire

// ----- hdl/cht_engine.sv -----
// Table sequencer: bucket head memory, node memory and free list control.
`default_nettype none

module cht_engine #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [cht_pkg::REQ_W-1:0]     req_type,
	input  wire logic [cht_pkg::KEY_W-1:0]     key,
	input  wire logic [$clog2(BUCKETS+1)-1:0]  divisor,
	output logic                               idle,
	output logic                               res_valid,
	output cht_pkg::cht_result_t               res,
	input  wire logic                          res_ready
);
	import cht_pkg::*;

	localparam int NW   = $clog2(NODES + 1);
	localparam int IW   = $clog2(NODES);
	localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW   = $clog2(NODES + 1);
	localparam int NE_W = KEY_W + NW;
	localparam logic [NW-1:0] NULL_IDX = NW'(NODES);

	cht_state_t state_q, state_nxt;

	// memories
	logic [NW-1:0]   head_mem_q [BUCKETS];
	logic [NE_W-1:0] node_mem_q [NODES];
	logic [NW-1:0]   head_rd_q;
	logic [NE_W-1:0] node_rd_q;

	logic            head_we;
	logic [BW-1:0]   head_waddr;
	logic [NW-1:0]   head_wdata;
	logic [BW-1:0]   head_raddr;
	logic            node_we;
	logic [IW-1:0]   node_waddr;
	logic [NE_W-1:0] node_wdata;
	logic [IW-1:0]   node_raddr;

	// control state
	logic [BW-1:0] clr_q;
	logic [NW-1:0] free_head_q;
	logic [NW-1:0] fresh_q;
	logic [NW-1:0] free_cnt_q;

	// item payload
	logic [REQ_W-1:0] req_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    bkt_q;
	logic [NW-1:0]    head_q;
	logic [IW-1:0]    new_q;
	logic [NW-1:0]    cur_q;
	logic [NW-1:0]    prev_q;
	logic [KEY_W-1:0] prev_key_q;
	logic [NW-1:0]    hit_link_q;
	logic [CW-1:0]    cnt_q;
	cht_result_t      res_q;

	logic             mod_start;
	logic             mod_done;
	logic [BW-1:0]    mod_rem;

	logic [KEY_W-1:0] nd_key;
	logic [NW-1:0]    nd_link;
	logic [CW-1:0]    cnt_nxt;
	logic             key_hit;
	logic             is_insert;
	logic             is_walk;
	logic             list_avail;

	assign nd_key     = node_rd_q[NE_W-1:NW];
	assign nd_link    = node_rd_q[NW-1:0];
	assign cnt_nxt    = cnt_q + CW'(1);
	assign key_hit    = (nd_key == key_q);
	assign is_insert  = (req_q == REQ_INSERT);
	assign is_walk    = (req_q == REQ_SEARCH) || (req_q == REQ_DELETE);
	assign list_avail = (free_head_q != NULL_IDX);

	cht_mod #(
		.BUCKETS(BUCKETS)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (key),
		.divisor(divisor),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// items are serialized; a read of an entry being written returns its old contents
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem_q[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem_q[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem_q[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem_q[node_raddr];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == BW'(BUCKETS - 1)) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nxt = ST_HASH;
			end
			ST_HASH: begin
				if (mod_done) begin
					if (is_insert && free_cnt_q == '0) state_nxt = ST_DONE;
					else if (is_insert || is_walk) state_nxt = ST_HEAD;
					else state_nxt = ST_DONE;
				end
			end
			ST_HEAD: begin
				if (is_insert) begin
					state_nxt = list_avail ? ST_POP : ST_INS_WR;
				end else begin
					state_nxt = (head_rd_q < NULL_IDX) ? ST_WALK : ST_DONE;
				end
			end
			ST_POP:    state_nxt = ST_INS_WR;
			ST_INS_WR: state_nxt = ST_DONE;
			ST_WALK: begin
				if (key_hit) begin
					state_nxt = (req_q == REQ_DELETE) ? ST_UNLINK : ST_DONE;
				end else if (nd_link < NULL_IDX && cnt_nxt != CW'(NODES)) begin
					state_nxt = ST_WALK;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_UNLINK: state_nxt = ST_FREE;
			ST_FREE:   state_nxt = ST_DONE;
			ST_DONE: begin
				if (res_ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		idle       = 1'b0;
		res_valid  = 1'b0;
		mod_start  = 1'b0;
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = hit_link_q;
		head_raddr = mod_rem;
		node_we    = 1'b0;
		node_waddr = cur_q[IW-1:0];
		node_wdata = {key_q, free_head_q};
		node_raddr = cur_q[IW-1:0];
		case (state_q)
			ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = NULL_IDX;
			end
			ST_IDLE: begin
				idle      = 1'b1;
				mod_start = start;
			end
			ST_HEAD: begin
				node_raddr = is_insert ? free_head_q[IW-1:0] : head_rd_q[IW-1:0];
			end
			ST_WALK: begin
				node_raddr = nd_link[IW-1:0];
			end
			ST_INS_WR: begin
				node_we    = 1'b1;
				node_waddr = new_q;
				node_wdata = {key_q, head_q};
				head_we    = 1'b1;
				head_waddr = bkt_q;
				head_wdata = NW'(new_q);
			end
			ST_UNLINK: begin
				if (prev_q == NULL_IDX) begin
					head_we = 1'b1;
				end else begin
					node_we    = 1'b1;
					node_waddr = prev_q[IW-1:0];
					node_wdata = {prev_key_q, hit_link_q};
				end
			end
			ST_FREE: begin
				// freed node is threaded onto the free list
				node_we = 1'b1;
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			free_head_q <= NULL_IDX;
			fresh_q     <= '0;
			free_cnt_q  <= NW'(NODES);
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + BW'(1);
				ST_HEAD: begin
					if (is_insert && !list_avail) fresh_q <= fresh_q + NW'(1);
				end
				ST_POP:    free_head_q <= nd_link;
				ST_INS_WR: free_cnt_q <= free_cnt_q - NW'(1);
				ST_FREE: begin
					free_head_q <= cur_q;
					free_cnt_q  <= free_cnt_q + NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					req_q <= req_type;
					key_q <= key;
					res_q <= '0;
				end
			end
			ST_HASH: begin
				if (mod_done) begin
					bkt_q <= mod_rem;
					if (is_insert && free_cnt_q == '0) res_q.status <= 1'b1;
				end
			end
			ST_HEAD: begin
				head_q <= head_rd_q;
				cur_q  <= head_rd_q;
				prev_q <= NULL_IDX;
				cnt_q  <= '0;
				new_q  <= list_avail ? free_head_q[IW-1:0] : fresh_q[IW-1:0];
			end
			ST_WALK: begin
				cnt_q <= cnt_nxt;
				if (key_hit) begin
					res_q.position <= POS_W'(cnt_nxt);
					hit_link_q     <= nd_link;
				end else begin
					prev_q     <= cur_q;
					prev_key_q <= nd_key;
					cur_q      <= nd_link;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	a_free_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= NW'(NODES))
		else $error("free node count above pool size");

	a_insert_has_node: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS_WR |-> free_cnt_q != '0)
		else $error("insert commit with empty pool");

	a_walk_node_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> cur_q < NULL_IDX)
		else $error("chain walk on invalid node");

	a_mod_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == ST_HASH)
		else $error("remainder finished outside hash state");

	a_free_list_counted: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != NULL_IDX |-> free_cnt_q != '0)
		else $error("free list populated while count is zero");

endmodule

`default_nettype wire

// ----- hdl/chained_hash_table.sv -----
// Top level of the chained hash table: config register, input and output channels.
`default_nettype none

// Hash table of 31-bit keys with separate chaining. Each transaction is an insert,
// search or delete; each produces exactly one result (position, status). The
// bucket is key mod bucket_count (0 acts as 1, values above BUCKETS act as
// BUCKETS). Inserts go to the chain head; search and delete report the 1-based
// position of the first match, or 0. An insert into a full pool returns status 1.
// Sequencing: one transaction at a time. After acceptance, the remainder unit
// shifts in the key bits and signals done, then the bucket head is read, then
// the chain is walked node by node; insert adds a free list pop when a freed
// node is reused, then the write; delete adds an unlink and a free step. The
// result then passes to the output register and the sequencer back to idle; a
// refused insert or an unused request goes from the remainder unit straight to
// the result. in_stall stays high while a transaction is in flight, but the
// next one is taken while the previous result still waits in the output
// register. After reset the bucket head memory is cleared, one entry per cycle;
// in_stall is high meanwhile (config writes are accepted). Write bucket_count
// only while the block is idle.
module chained_hash_table #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_wr_en,
	input  wire logic [cht_pkg::CFG_W-1:0]   cfg_wr_data,
	// request channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [cht_pkg::REQ_W-1:0]   req_type,
	input  wire logic [cht_pkg::KEY_W-1:0]   key,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [cht_pkg::POS_W-1:0]        position,
	output logic                             status
);
	import cht_pkg::*;

	localparam int DW = $clog2(BUCKETS + 1);

	logic [CFG_W-1:0] bucket_count_q;
	logic [DW-1:0]    eff_div;

	logic        eng_idle;
	logic        eng_res_valid;
	cht_result_t eng_res;
	logic        res_ready;
	logic        in_accept;

	logic             out_valid_q;
	logic [POS_W-1:0] position_q;
	logic             status_q;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	// clamp the divisor to 1..BUCKETS
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_div = DW'(1);
		end else if (32'(bucket_count_q) > 32'(BUCKETS)) begin
			eff_div = DW'(BUCKETS);
		end else begin
			eff_div = DW'(bucket_count_q);
		end
	end

	// a new transaction enters only when the sequencer is idle
	assign in_stall  = !eng_idle;
	assign in_accept = in_valid && !in_stall;

	cht_engine #(
		.BUCKETS(BUCKETS),
		.NODES  (NODES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.req_type (req_type),
		.key      (key),
		.divisor  (eff_div),
		.idle     (eng_idle),
		.res_valid(eng_res_valid),
		.res      (eng_res),
		.res_ready(res_ready)
	);

	// output register: frees the sequencer while the consumer stalls
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && eng_res_valid) begin
			position_q <= eng_res.position;
			status_q   <= eng_res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign status    = status_q;

endmodule

`default_nettype wire
